// ===== hdl/brce_pkg.sv =====
// Shared types and constants for the baud rate code encoder.
// Used by the divider, datapath, controller and top level; no dependencies.
package brce_pkg;

    // Arithmetic widths.
    localparam int RATE_W    = 32;
    localparam int CODE_W    = 8;
    localparam int DIV_CNT_W = $clog2(RATE_W + 1);
    localparam int TZ_W      = 5;

    // Fast-rate test: 25000 = 2^3 * 3125. The rate without its low three bits
    // is divided by 3125 through a reciprocal that is exact for every
    // 29-bit value (rounded-up reciprocal with 29 + 12 fraction bits).
    localparam int STEP_SHIFT = 3;
    localparam int STEP_ODD_W = 12;
    localparam int RECIP_IN_W = RATE_W - STEP_SHIFT;
    localparam int RECIP_W    = RECIP_IN_W + 1;
    localparam int RECIP_SH   = RECIP_IN_W + STEP_ODD_W;
    localparam int PROD_W     = RECIP_IN_W + RECIP_W;
    localparam int QUO_W      = PROD_W - RECIP_SH;
    localparam logic [STEP_ODD_W-1:0] STEP_ODD  = 12'd3125;
    localparam logic [RECIP_W-1:0]    RECIP_MUL =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(STEP_ODD) - 64'd1) / 64'(STEP_ODD));

    // Rate rules.
    localparam logic [RATE_W-1:0] FAST_CLOCK  = 32'(48000000 / 16);
    localparam logic [CODE_W-1:0] FAST_BASE   = 8'd128;
    localparam logic [RATE_W-1:0] LOW_LIMIT   = 32'd150;
    localparam logic [RATE_W-1:0] ODD_RATE_A  = 32'd134;
    localparam logic [RATE_W-1:0] ODD_RATE_B  = 32'd135;
    localparam logic [CODE_W-1:0] ODD_CODE    = 8'd127;
    localparam logic [RATE_W-1:0] DIRECT_LOW  = 32'd32;
    localparam logic [RATE_W-1:0] DIRECT_HIGH = 32'd127;
    localparam logic [RATE_W-1:0] BASE_ODD    = 32'd75;
    localparam logic [RATE_W-1:0] TRIPLE_ODD  = 32'd225;
    localparam logic [CODE_W-1:0] TRIPLE_FLAG = 8'h10;
    // Largest exponent: 2^15 = 32768 is the biggest allowed multiplier.
    localparam logic [TZ_W-1:0]   MAX_EXP     = 5'd15;
    localparam logic [TZ_W-1:0]   TZ_LIMIT    = 5'd16;

    // Which rule forms the result word.
    typedef enum logic [1:0] {
        K_REJECT,
        K_FAST,
        K_LOW,
        K_BASE
    } t_kind;

    // Controller state.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RECIP,
        S_CHECK,
        S_DIV,
        S_TZ,
        S_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic     load;
        logic     div_go;
        logic     tz_step;
        logic     out_load;
        t_kind    kind;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic div_done;
        logic rate_zero;
        logic rem_zero;
        logic rate_low;
        logic shift_lsb;
        logic tz_full;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hdl/baud_rate_code_encoder_unit.sv =====
// Baud rate code encoder, top level.
// Input channel: i_in_valid / o_in_ready carry one word, i_baud_rate, the
// requested line rate in bits per second.
// Output channel: o_out_valid / i_out_ready carry one word per input word:
// o_code_valid and the one-byte code o_rate_code (zero when rejected).
// One word is worked on at a time. The test for a multiple of 25000 goes
// through a reciprocal multiplication whose quotient is registered. A zero
// rate and rates below 150 go straight on to the output load; multiples of
// 25000 first run a bit-serial divider for 3000000 divided by the rate, and
// other rates are checked as 75 or 225 times a power of two, with trailing
// zero bits stripped one at a time, at most 16.
// A new word is accepted in the cycle after the previous result is loaded
// into the output register.
// The output register holds its word while the receiver stalls; work on the
// next word goes on and only the final load waits for the register to free.
// Reset (synchronous, active low) empties the output register, stops the
// divider and returns the controller to idle; nothing else needs clearing.
// Depends on brce_pkg, brce_ctrl and brce_dp.
module baud_rate_code_encoder_unit import brce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [RATE_W-1:0] i_baud_rate,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_code_valid,
    output logic [CODE_W-1:0] o_rate_code
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    brce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Arithmetic and output register.
    brce_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_baud_rate  (i_baud_rate),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_code_valid (o_code_valid),
        .o_rate_code  (o_rate_code)
    );

endmodule

// ===== hdl/brce_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on brce_pkg for widths.
module brce_div import brce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RATE_W-1:0] i_dividend,
    input  logic [RATE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [RATE_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [RATE_W-1:0]    r_dvd;
    logic [RATE_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_dsr;
    logic [RATE_W:0]      trial;
    logic [RATE_W:0]      diff;
    logic                 fits;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        trial = {r_rem, r_dvd[RATE_W-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = (trial >= {1'b0, r_dsr});
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(RATE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend register fills with quotient bits from the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            r_dvd <= {r_dvd[RATE_W-2:0], fits};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_dvd;

endmodule

// ===== hdl/brce_dp.sv =====
// Datapath: rate register, fast-rate reciprocal test, divider, trailing-zero
// shifter and output register. Depends on brce_pkg and brce_div.
module brce_dp import brce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [RATE_W-1:0] i_baud_rate,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_code_valid,
    output logic [CODE_W-1:0] o_rate_code
);

    logic [RATE_W-1:0] r_rate;
    logic [RATE_W-1:0] r_shift;
    logic [TZ_W-1:0]   r_tz;
    logic [QUO_W-1:0]  r_quo;
    logic              r_out_valid;
    logic              r_code_valid;
    logic [CODE_W-1:0] r_rate_code;

    logic [PROD_W-1:0]     recip_prod;
    logic [RECIP_IN_W-1:0] quo_back;
    logic                  div_done;
    logic [RATE_W-1:0]     div_quot;
    logic                  n_code_valid;
    logic [CODE_W-1:0]     n_rate_code;

    // The divider only ever forms 3000000 / rate.
    brce_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_go),
        .i_dividend  (FAST_CLOCK),
        .i_divisor   (r_rate),
        .o_done      (div_done),
        .o_quotient  (div_quot)
    );

    // Fast-rate test: registered quotient of the rate's upper bits by 3125, and its product with 3125.
    always_comb begin
        recip_prod = PROD_W'(r_rate[RATE_W-1:STEP_SHIFT]) * PROD_W'(RECIP_MUL);
        quo_back   = RECIP_IN_W'(r_quo) * RECIP_IN_W'(STEP_ODD);
    end

    always_ff @(posedge i_clk) begin
        r_quo <= recip_prod[PROD_W-1:RECIP_SH];
    end

    // Input word capture and the trailing-zero shifter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rate  <= i_baud_rate;
            r_shift <= i_baud_rate;
            r_tz    <= '0;
        end else if (i_cmd.tz_step) begin
            r_shift <= {1'b0, r_shift[RATE_W-1:1]};
            r_tz    <= r_tz + TZ_W'(1);
        end
    end

    // Result word for the rule the controller picked.
    always_comb begin
        n_code_valid = 1'b0;
        n_rate_code  = '0;
        unique case (i_cmd.kind)
            K_REJECT: begin
                n_code_valid = 1'b0;
            end
            K_FAST: begin
                // The quotient is at most 120, so it fits under the base bit.
                n_code_valid = 1'b1;
                n_rate_code  = FAST_BASE + div_quot[CODE_W-1:0];
            end
            K_LOW: begin
                if (r_rate == ODD_RATE_A || r_rate == ODD_RATE_B) begin
                    n_code_valid = 1'b1;
                    n_rate_code  = ODD_CODE;
                end else if (r_rate >= DIRECT_LOW && r_rate <= DIRECT_HIGH) begin
                    n_code_valid = 1'b1;
                    n_rate_code  = r_rate[CODE_W-1:0];
                end
            end
            K_BASE: begin
                // The odd part must be 75 or 3 * 75, the exponent at most 15.
                if (r_tz <= MAX_EXP && r_shift == BASE_ODD) begin
                    n_code_valid = 1'b1;
                    n_rate_code  = CODE_W'(r_tz);
                end else if (r_tz <= MAX_EXP && r_shift == TRIPLE_ODD) begin
                    n_code_valid = 1'b1;
                    n_rate_code  = TRIPLE_FLAG | CODE_W'(r_tz);
                end
            end
            default: begin
                n_code_valid = 1'b0;
            end
        endcase
    end

    // Output register; it holds its word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_code_valid <= n_code_valid;
            r_rate_code  <= n_rate_code;
        end
    end

    // Status back to the controller. A multiple of 25000 has its low three
    // bits clear and its upper bits an exact multiple of 3125.
    always_comb begin
        o_stat.div_done  = div_done;
        o_stat.rate_zero = (r_rate == '0);
        o_stat.rem_zero  = (r_rate[STEP_SHIFT-1:0] == '0)
                           && (quo_back == r_rate[RATE_W-1:STEP_SHIFT]);
        o_stat.rate_low  = (r_rate < LOW_LIMIT);
        o_stat.shift_lsb = r_shift[0];
        o_stat.tz_full   = (r_tz == TZ_LIMIT);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_valid = r_code_valid;
    assign o_rate_code  = r_rate_code;

    // A rejected word always carries a zero code.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_code_valid |-> r_rate_code == '0)
        else $error("rejected word carries a nonzero code");

    // A loaded result is presented on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

    // The shifter only drops zero bits and never runs past its limit.
    a_tz_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tz_step |-> !r_shift[0] && r_tz < TZ_LIMIT)
        else $error("trailing-zero step on a set bit or past the limit");

endmodule

// ===== hdl/brce_ctrl.sv =====
// Controller state machine sequencing the fast-rate test, divider, shifter
// and output load. Depends on brce_pkg.
module brce_ctrl import brce_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    t_kind  r_kind;
    t_kind  n_kind;

    // State and chosen-rule registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_REJECT;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_kind         = r_kind;
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.div_go   = 1'b0;
        o_cmd.tz_step  = 1'b0;
        o_cmd.out_load = 1'b0;
        o_cmd.kind     = r_kind;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RECIP;
                end
            end
            S_RECIP: begin
                // The reciprocal quotient for the fast-rate test registers here.
                n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_stat.rate_zero) begin
                    n_kind  = K_REJECT;
                    n_state = S_DONE;
                end else if (i_stat.rem_zero) begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_DIV;
                end else if (i_stat.rate_low) begin
                    n_kind  = K_LOW;
                    n_state = S_DONE;
                end else begin
                    n_state = S_TZ;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_kind  = K_FAST;
                    n_state = S_DONE;
                end
            end
            S_TZ: begin
                // Strip trailing zeros, one per cycle, up to the limit of 16.
                if (i_stat.shift_lsb || i_stat.tz_full) begin
                    n_kind  = K_BASE;
                    n_state = S_DONE;
                end else begin
                    o_cmd.tz_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
